// ===== hw/rtl/spa_pkg.sv =====
// Shared types, field widths and codes for the slot pool allocator.
package spa_pkg;

    // Default pool size.
    localparam int SLOTS_DEFAULT = 64;

    // Fixed field widths of the request and response words.
    localparam int SLOT_W = 6;
    localparam int STATUS_W = 2;
    localparam int USE_W = 7;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

    // Request word.
    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
        logic [USE_W-1:0]    slots_in_use;
    } rsp_t;

endpackage

// ===== hw/rtl/spa_link_mem.sv =====
// Next and previous link memories of the slot list, with registered read data.
module spa_link_mem #(
    parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(SLOTS)-1:0]          rd_addr,
    input  logic                              nx_we,
    input  logic [$clog2(SLOTS)-1:0]          nx_addr,
    input  logic [$clog2(SLOTS+1):0]          nx_wdata,
    input  logic                              pv_we,
    input  logic [$clog2(SLOTS)-1:0]          pv_addr,
    input  logic [$clog2(SLOTS+1)-1:0]        pv_wdata,
    output logic [$clog2(SLOTS+1):0]          nx_rdata,
    output logic [$clog2(SLOTS+1)-1:0]        pv_rdata
);
    import spa_pkg::*;

    localparam int LW = $clog2(SLOTS+1);

    // Each next entry carries the in-use mark above the link.
    logic [LW:0]   next_mem [SLOTS];
    logic [LW-1:0] prev_mem [SLOTS];

    // Write ports.
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_addr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_addr] <= pv_wdata;
        end
    end

    // Shared read address, registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            nx_rdata <= next_mem[rd_addr];
            pv_rdata <= prev_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/slot_pool_allocator.sv =====
// Top level of the slot pool allocator: sequencer, list pointers and response register.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-------------------------------------------
//   request | req_valid | req_stall | req: operation, slot_index
//   response| rsp_valid | rsp_stall | rsp: granted_slot, status, slots_in_use
//
// An allocate, a refused release and a release of the tail slot pass from idle through
// read, evaluate and done back to idle. Any other release also passes the link and tail
// states, since the single write port of the next-link memory takes its up to three link
// updates one after another. After reset a clearing pass writes the initial links;
// requests are stalled during it. A stalled response holds the sequencer in its final
// state; the next request is still accepted while the last response waits.
module slot_pool_allocator #(
    parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spa_pkg::rsp_t rsp
);
    import spa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS+1);
    localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;
    localparam int UW = (LW > USE_W) ? LW : USE_W;
    localparam logic [LW-1:0] NONE = LW'(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_LINK = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       init_reg, init_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [LW-1:0]       free_reg, free_next;
    logic [LW-1:0]       count_reg, count_next;
    logic                op_reg, op_next;
    logic                slot_ok_reg, slot_ok_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [LW-1:0]       p_reg, p_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [IW-1:0]       grant_reg, grant_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                nx_we;
    logic [IW-1:0]       nx_addr;
    logic [LW:0]         nx_wdata;
    logic                pv_we;
    logic [IW-1:0]       pv_addr;
    logic [LW-1:0]       pv_wdata;
    logic [LW:0]         nx_rdata;
    logic [LW-1:0]       pv_rdata;

    logic                was_full;
    logic                rd_used;
    logic [LW-1:0]       rd_link;
    logic [CW-1:0]       req_slot_ext;
    logic [CW-1:0]       grant_ext;
    logic [UW-1:0]       count_ext;

    spa_link_mem #(
        .SLOTS(SLOTS)
    ) u_link_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .nx_we    (nx_we),
        .nx_addr  (nx_addr),
        .nx_wdata (nx_wdata),
        .pv_we    (pv_we),
        .pv_addr  (pv_addr),
        .pv_wdata (pv_wdata),
        .nx_rdata (nx_rdata),
        .pv_rdata (pv_rdata)
    );

    // Decoded fields of the word read from the next-link memory.
    assign rd_used = nx_rdata[LW];
    assign rd_link = nx_rdata[LW-1:0];
    assign was_full = (free_reg == NONE);
    assign req_slot_ext = CW'(req.slot_index);

    // Requests are taken only while the sequencer waits in idle.
    assign req_stall = (state_reg != S_IDLE);

    // Sequencer: at most one memory read, then link updates one write per memory per cycle.
    always_comb
    begin
        state_next = state_reg;
        init_next = init_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        free_next = free_reg;
        count_next = count_reg;
        op_next = op_reg;
        slot_ok_next = slot_ok_reg;
        slot_next = slot_reg;
        p_next = p_reg;
        n_next = n_reg;
        grant_next = grant_reg;
        status_next = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        rd_en = 1'b0;
        rd_addr = slot_reg;
        nx_we = 1'b0;
        nx_addr = slot_reg;
        nx_wdata = {1'b0, NONE};
        pv_we = 1'b0;
        pv_addr = slot_reg;
        pv_wdata = NONE;
        grant_ext = CW'(grant_reg);
        count_ext = UW'(count_reg);

        // The response register empties when its word is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // Clearing pass: entry i links to i+1 and i-1 (none before entry 0), not in use.
                nx_we = 1'b1;
                nx_addr = init_reg;
                nx_wdata = {1'b0, LW'(init_reg) + LW'(1)};
                pv_we = 1'b1;
                pv_addr = init_reg;
                pv_wdata = (init_reg == '0) ? NONE : LW'(init_reg) - LW'(1);
                init_next = init_reg + IW'(1);
                if (init_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = req.operation;
                    slot_ok_next = (req_slot_ext < SLOTS_C);
                    slot_next = req_slot_ext[IW-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Read the free head on allocate, the named slot on release.
                if (op_reg == OP_ALLOC)
                begin
                    rd_en = !was_full;
                    rd_addr = free_reg[IW-1:0];
                end
                else
                begin
                    rd_en = slot_ok_reg;
                    rd_addr = slot_reg;
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                grant_next = '0;
                status_next = ST_OK;
                state_next = S_DONE;
                if (op_reg == OP_ALLOC)
                begin
                    if (was_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // Mark the free head in use and advance along its link.
                        nx_we = 1'b1;
                        nx_addr = free_reg[IW-1:0];
                        nx_wdata = {1'b1, rd_link};
                        free_next = rd_link;
                        count_next = count_reg + LW'(1);
                        grant_next = free_reg[IW-1:0];
                    end
                end
                else if (!slot_ok_reg || !rd_used)
                begin
                    status_next = ST_NOT_IN_USE;
                end
                else if (slot_reg == tail_reg)
                begin
                    // The tail stays in place; only its mark clears.
                    nx_we = 1'b1;
                    nx_addr = slot_reg;
                    nx_wdata = {1'b0, rd_link};
                    if (was_full)
                    begin
                        free_next = LW'(slot_reg);
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - LW'(1);
                    end
                end
                else
                begin
                    // The slot becomes the new tail: clear it and point back to the old one.
                    nx_we = 1'b1;
                    nx_addr = slot_reg;
                    nx_wdata = {1'b0, NONE};
                    pv_we = 1'b1;
                    pv_addr = slot_reg;
                    pv_wdata = LW'(tail_reg);
                    p_next = pv_rdata;
                    n_next = rd_link;
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                // Bridge the neighbors of the released slot.
                if (slot_reg == head_reg)
                begin
                    head_next = n_reg[IW-1:0];
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_addr = p_reg[IW-1:0];
                    nx_wdata = {1'b1, n_reg};
                end
                pv_we = 1'b1;
                pv_addr = n_reg[IW-1:0];
                pv_wdata = p_reg;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                // Append after the old tail, which is in use only when the pool was full.
                nx_we = 1'b1;
                nx_addr = tail_reg;
                nx_wdata = {was_full, LW'(slot_reg)};
                tail_next = slot_reg;
                if (was_full)
                begin
                    free_next = LW'(slot_reg);
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - LW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result to the response register once it is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.granted_slot = grant_ext[SLOT_W-1:0];
                    rsp_next.status = status_reg;
                    rsp_next.slots_in_use = count_ext[USE_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and list pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg <= '0;
            head_reg <= '0;
            tail_reg <= LAST;
            free_reg <= '0;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Item payload and response word.
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        slot_ok_reg <= slot_ok_next;
        slot_reg <= slot_next;
        p_reg <= p_next;
        n_reg <= n_next;
        grant_reg <= grant_next;
        status_reg <= status_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== bench/slot_pool_allocator_test.sv =====
// Self-checking testbench for the slot pool allocator: directed table, then random traffic.
module slot_pool_allocator_test;

    import spa_pkg::*;

    localparam int POOL = SLOTS_DEFAULT;
    localparam logic [SLOT_W:0] NO_LINK = (SLOT_W+1)'(POOL);
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // One row of the directed table: request, repeat count, and a typed
    // expectation where one is given (otherwise the pool model decides).
    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
        logic [6:0]        repeats;
        logic              fixed;
        rsp_t              want;
    } plan_row_t;

    localparam logic FIXED = 1'b1;
    localparam logic MODELED = 1'b0;
    localparam rsp_t ANY = '0;
    localparam int PLAN_ROWS = 20;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{OP_ALLOC,   6'd0,  7'd1,  FIXED,   '{6'd0, ST_OK, 7'd1}},
        '{OP_RELEASE, 6'd0,  7'd1,  FIXED,   '{6'd0, ST_OK, 7'd0}},
        '{OP_RELEASE, 6'd0,  7'd1,  FIXED,   '{6'd0, ST_NOT_IN_USE, 7'd0}},
        '{OP_RELEASE, 6'd63, 7'd1,  FIXED,   '{6'd0, ST_NOT_IN_USE, 7'd0}},
        '{OP_ALLOC,   6'd63, 7'd1,  MODELED, ANY},
        '{OP_ALLOC,   6'd0,  7'd62, MODELED, ANY},
        '{OP_ALLOC,   6'd0,  7'd1,  MODELED, ANY},
        '{OP_ALLOC,   6'd42, 7'd1,  FIXED,   '{6'd0, ST_FULL, 7'd64}},
        '{OP_RELEASE, 6'd0,  7'd1,  MODELED, ANY},
        '{OP_ALLOC,   6'd21, 7'd1,  FIXED,   '{6'd0, ST_OK, 7'd64}},
        '{OP_RELEASE, 6'd32, 7'd1,  MODELED, ANY},
        '{OP_RELEASE, 6'd1,  7'd1,  MODELED, ANY},
        '{OP_ALLOC,   6'd0,  7'd2,  MODELED, ANY},
        '{OP_ALLOC,   6'd0,  7'd1,  FIXED,   '{6'd0, ST_FULL, 7'd64}},
        '{OP_RELEASE, 6'd63, 7'd1,  MODELED, ANY},
        '{OP_RELEASE, 6'd21, 7'd1,  MODELED, ANY},
        '{OP_RELEASE, 6'd42, 7'd1,  MODELED, ANY},
        '{OP_RELEASE, 6'd42, 7'd1,  FIXED,   '{6'd0, ST_NOT_IN_USE, 7'd61}},
        '{OP_ALLOC,   6'd0,  7'd1,  MODELED, ANY},
        '{OP_RELEASE, 6'd2,  7'd1,  MODELED, ANY}
    };

    // Random phases: share of allocates in percent, idling on or off, length.
    localparam int PHASES = 5;
    localparam int PHASE_ALLOC_PCT [PHASES] = '{75, 50, 25, 65, 45};
    localparam bit PHASE_IDLE [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam int PHASE_LEN [PHASES] = '{120, 100, 100, 80, 70};

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Shadow copy of the pool: forward and backward links with an extra
    // invalid bit, list pointers, use count and per-slot in-use marks.
    logic [SLOT_W:0] link_fwd [POOL];
    logic [SLOT_W:0] link_back [POOL];
    logic [SLOT_W:0] busy_head;
    logic [SLOT_W:0] free_ptr;
    logic [SLOT_W:0] tail_ptr;
    logic [USE_W-1:0] taken_cnt;
    logic taken [POOL];

    rsp_t awaited_rsp [$];
    bit idle_on;
    int errors = 0;
    int cycle_count = 0;
    int words_sent;
    int allocs_sent;
    int full_refusals;
    int free_releases;

    slot_pool_allocator #(
        .SLOTS(POOL)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // Clock with a 10 unit period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Put the shadow pool in its reset state: one list in index order, all free.
    task automatic pool_clear();
        for (int i = 0; i < POOL; i++)
        begin
            link_fwd[i] = (SLOT_W+1)'(i + 1);
            link_back[i] = (i == 0) ? NO_LINK : (SLOT_W+1)'(i - 1);
            taken[i] = 1'b0;
        end
        busy_head = '0;
        free_ptr = '0;
        tail_ptr = (SLOT_W+1)'(POOL - 1);
        taken_cnt = '0;
    endtask

    // Apply one request word to the shadow pool and return the response it earns.
    function automatic rsp_t pool_apply(req_t w);
        rsp_t r;
        logic [SLOT_W:0] s;
        logic [SLOT_W:0] p;
        logic [SLOT_W:0] n;
        logic was_full;
        r = '0;
        r.status = ST_OK;
        if (w.operation == OP_ALLOC)
        begin
            if (free_ptr >= POOL)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                s = free_ptr;
                r.granted_slot = s[SLOT_W-1:0];
                taken[s[SLOT_W-1:0]] = 1'b1;
                free_ptr = link_fwd[s[SLOT_W-1:0]];
                taken_cnt = taken_cnt + 1'b1;
            end
        end
        else
        begin
            s = {1'b0, w.slot_index};
            if (s >= POOL || !taken[s[SLOT_W-1:0]])
            begin
                r.status = ST_NOT_IN_USE;
            end
            else
            begin
                was_full = (free_ptr >= POOL);
                // The tail slot stays where it is; any other slot moves to the tail.
                if (s != tail_ptr)
                begin
                    p = link_back[s[SLOT_W-1:0]];
                    n = link_fwd[s[SLOT_W-1:0]];
                    if (s == busy_head)
                        busy_head = n;
                    else if (p < POOL)
                        link_fwd[p[SLOT_W-1:0]] = n;
                    if (n < POOL)
                        link_back[n[SLOT_W-1:0]] = p;
                    link_fwd[tail_ptr[SLOT_W-1:0]] = s;
                    link_back[s[SLOT_W-1:0]] = tail_ptr;
                    link_fwd[s[SLOT_W-1:0]] = NO_LINK;
                    tail_ptr = s;
                end
                if (was_full)
                    free_ptr = s;
                taken[s[SLOT_W-1:0]] = 1'b0;
                if (taken_cnt > 0)
                    taken_cnt = taken_cnt - 1'b1;
            end
        end
        r.slots_in_use = taken_cnt;
        return r;
    endfunction

    // Offer one request word, wait for it to be taken, then log its expectation.
    task automatic offer_word(req_t w, logic fixed, rsp_t want);
        rsp_t modeled;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req = w;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        modeled = pool_apply(w);
        awaited_rsp.push_back(fixed ? want : modeled);
        words_sent++;
        if (w.operation == OP_ALLOC)
            allocs_sent++;
        if (modeled.status == ST_FULL)
            full_refusals++;
        if (modeled.status == ST_NOT_IN_USE)
            free_releases++;
        @(negedge clk);
    endtask

    // Response side: stalls in random bursts while idling is on.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rsp_stall = 1'b1;
            end
            else
            begin
                rsp_stall = 1'b0;
            end
        end
    end

    // Compare each accepted response word with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("Unexpected response word: slot %0d status %0d in use %0d",
                             rsp.granted_slot, rsp.status, rsp.slots_in_use);
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.granted_slot !== want.granted_slot || rsp.status !== want.status ||
                    rsp.slots_in_use !== want.slots_in_use)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $write("Mismatch: expected slot %0d status %0d in use %0d, ",
                               want.granted_slot, want.status, want.slots_in_use);
                        $display("got slot %0d status %0d in use %0d",
                                 rsp.granted_slot, rsp.status, rsp.slots_in_use);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d responses outstanding.", awaited_rsp.size());
            $display("FAIL slot_pool_allocator");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        req_t w;
        int pick;
        int start;
        words_sent = 0;
        allocs_sent = 0;
        full_refusals = 0;
        free_releases = 0;
        idle_on = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rst_n = 1'b0;
        pool_clear();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed table, with some idling so gaps also land on these words.
        idle_on = 1'b1;
        for (int row = 0; row < PLAN_ROWS; row++)
        begin
            for (int k = 0; k < PLAN[row].repeats; k++)
            begin
                w.operation = PLAN[row].operation;
                w.slot_index = PLAN[row].slot_index;
                offer_word(w, PLAN[row].fixed, PLAN[row].want);
            end
        end

        // Random phases. Releases mostly name a slot that is in use.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_on = PHASE_IDLE[ph];
            for (int k = 0; k < PHASE_LEN[ph]; k++)
            begin
                w.slot_index = SLOT_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < PHASE_ALLOC_PCT[ph])
                begin
                    w.operation = OP_ALLOC;
                end
                else
                begin
                    w.operation = OP_RELEASE;
                    if ($urandom_range(0, 99) < 85)
                    begin
                        start = $urandom_range(0, POOL - 1);
                        for (int j = 0; j < POOL; j++)
                        begin
                            pick = (start + j) % POOL;
                            if (taken[pick])
                            begin
                                w.slot_index = SLOT_W'(pick);
                                break;
                            end
                        end
                    end
                end
                offer_word(w, MODELED, ANY);
            end
            req_valid = 1'b0;

            // After the second phase, hold off the next phase until every response is in.
            if (ph == 1)
            begin
                while (awaited_rsp.size() != 0)
                    @(negedge clk);
            end
        end

        // Drain, then watch for stray responses.
        req_valid = 1'b0;
        idle_on = 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d request words: %0d allocates and %0d releases.",
                 words_sent, allocs_sent, words_sent - allocs_sent);
        $display("Saw %0d refusals on a full pool and %0d releases of free slots; %0d mismatches.",
                 full_refusals, free_releases, errors);
        if (errors == 0)
            $display("PASS slot_pool_allocator");
        else
            $display("FAIL slot_pool_allocator");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/spa_pkg.sv
hw/rtl/spa_link_mem.sv
hw/rtl/slot_pool_allocator.sv
bench/slot_pool_allocator_test.sv
